[hdl/mel_to_frequency_defines.svh]
// Assertion macros for the mel to frequency RTL.
// Depends on nothing; included by mel_to_frequency, the module that carries assertions.
`ifndef MEL_TO_FREQUENCY_DEFINES_SVH
`define MEL_TO_FREQUENCY_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define M2F_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define M2F_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/m2f_pkg.sv]
// Types, constants and helper functions for the mel to frequency block.
// No dependencies.
package m2f_pkg;

  localparam int unsigned HornerTerms = 12;
  // Two front-end stages, two registers per Horner cell, scaling and output.
  localparam int unsigned Stages      = 2 * HornerTerms + 4;

  localparam logic [63:0] K0Q40   = 64'd1407513899;
  localparam logic [63:0] K1Q40   = 64'd1515559571;
  localparam logic [63:0] K2Q40   = 64'd109058192581;
  localparam logic [31:0] Ln2Q31  = 32'd1488522236;
  localparam logic [31:0] OneQ31  = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_OSH    = 2'd0,
    MODE_LINDSAY = 2'd1,
    MODE_SLANEY = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Path taken by an item through the cell chain.
  typedef enum logic [1:0] {
    PATH_EXP = 2'd0,
    PATH_LIN = 2'd1,
    PATH_BIG = 2'd2,
    PATH_ZERO = 2'd3
  } path_t;

  // Everything one cell hands to the next.
  typedef struct packed {
    logic               valid;
    path_t              path;
    logic               scale625;   // mode 1 scaling
    logic               slaney;     // 1000*E form, no minus one
    logic signed [11:0] n;          // integer part of the exponent
    logic [31:0]        x;          // fraction times ln2, Q31
    logic [31:0]        t;          // Horner accumulator, Q31
    logic signed [63:0] acc;        // linear result or final product
  } cell_data_t;

endpackage

[hdl/m2f_if.sv]
// Valid/ready stream interface used by all channels of the converter.
// Width set by parameter; no package dependency.
interface m2f_if #(parameter int unsigned W = 32) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hdl/mel_to_frequency.sv]
// Top level of the mel to frequency converter: front end, Horner cell chain,
// scaling and saturating output. Depends on m2f_pkg, m2f_if, m2f_horner_cell.
//
// Usage: mel values (signed Q16.16) enter on mel_ch; frequencies (signed
// Q20.12) with a saturation flag leave on freq_ch as {saturated, frequency_hz}.
// The formula is selected by the two-bit register written on cfg_ch, which
// is always ready; reset sets it to mode 0. Write it only while no request
// is in flight.
// There are 28 register stages: two front-end stages forming the exponent,
// twelve Horner cells of two registers each, a scaling stage and the output
// register. Throughput is one request per cycle while the receiver takes
// results, set by the cell chain, which advances as a whole. When the
// receiver stalls with a result held in the output register, the whole
// chain holds and mel_ch ready falls in the same cycle; it rises again
// once the receiver takes the result. Empty slots in the chain are not
// squeezed out during a stall.
// Reset clears all valid bits in the chain and the output register.
module mel_to_frequency (
  input logic clk,
  input logic rst,
  m2f_if.sink   mel_ch,
  m2f_if.sink   cfg_ch,
  m2f_if.source freq_ch
);
  `include "mel_to_frequency_defines.svh"

  localparam int unsigned N = m2f_pkg::HornerTerms;

  m2f_pkg::mode_t mode;
  logic en;
  logic out_valid;
  logic [32:0] out_data;

  // Stage registers.
  logic               s1_valid;
  m2f_pkg::path_t     s1_path;
  logic [1:0]         s1_mode;
  logic signed [63:0] s1_y;       // exponent in Q32
  logic signed [63:0] s1_lin;
  m2f_pkg::cell_data_t chain [0:N];
  m2f_pkg::cell_data_t sc;

  assign en = !out_valid || freq_ch.ready;
  assign mel_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= m2f_pkg::MODE_OSH;
    end else if (cfg_ch.valid) begin
      mode <= m2f_pkg::mode_t'(cfg_ch.data[1:0]);
    end
  end

  // Stage 1: choose formula, form the exponent product and the linear value.
  logic signed [31:0] m32;
  logic signed [63:0] m;
  logic signed [63:0] d;
  logic        [26:0] d27;
  logic signed [31:0] k01;
  logic        [36:0] k2;
  logic signed [31:0] half;
  logic        [31:0] biased;
  logic        [63:0] third;
  logic signed [63:0] sixth;
  logic signed [63:0] lin_q;
  logic signed [63:0] kmul;
  m2f_pkg::path_t     p1;
  always_comb begin
    m32   = signed'(mel_ch.data[31:0]);
    m     = 64'(m32);
    d     = m - 64'sd983040;
    if (d > 64'sd67108864) d = 64'sd67108864;
    d27   = d[26:0];
    k01   = (mode == m2f_pkg::MODE_OSH) ? signed'(m2f_pkg::K0Q40[31:0])
                                        : signed'(m2f_pkg::K1Q40[31:0]);
    k2    = m2f_pkg::K2Q40[36:0];
    // Linear part: floor(25m/6) is 4m plus floor(floor(m/2)/3). The bias
    // keeps the dividend of the third positive, and a reciprocal multiply
    // gives the exact quotient for any 32-bit dividend.
    half   = m32 >>> 1;
    biased = unsigned'(half) + 32'hC000_0000;
    third  = 64'(biased) * 64'h0000_0000_AAAA_AAAB;
    sixth  = signed'(64'(third[63:33])) - 64'sd1073741824;
    lin_q  = (m <<< 2) + sixth;
    p1    = m2f_pkg::PATH_EXP;
    kmul  = '0;
    // Both operands are 32 bits wide in the first two modes, 27 by 37 bits
    // in the Slaney mode.
    unique case (mode) inside
      m2f_pkg::MODE_OSH, m2f_pkg::MODE_LINDSAY: kmul = 64'(m32) * 64'(k01);
      m2f_pkg::MODE_SLANEY: begin
        if (m < 64'sd983040) p1 = m2f_pkg::PATH_LIN;
        else kmul = signed'(64'(d27) * 64'(k2));
      end
      default: p1 = m2f_pkg::PATH_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= mel_ch.valid;
    end
    if (en) begin
      s1_path <= p1;
      s1_mode <= mode;
      s1_y    <= kmul >>> 24;
      s1_lin  <= lin_q;
    end
  end

  // Stage 2: split exponent, scale the fraction by ln2, seed the chain.
  logic signed [31:0] n_full;
  logic [63:0]        fx;
  always_comb begin
    n_full = s1_y[63:32];
    fx     = 64'(s1_y[31:0]) * 64'(m2f_pkg::Ln2Q31);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= s1_valid;
    end
    if (en) begin
      chain[0].path     <= (s1_path == m2f_pkg::PATH_EXP && n_full >= 32'sd20)
                           ? m2f_pkg::PATH_BIG : s1_path;
      chain[0].scale625 <= (s1_mode == m2f_pkg::MODE_LINDSAY);
      chain[0].slaney   <= (s1_mode == m2f_pkg::MODE_SLANEY);
      chain[0].n        <= (n_full < -32'sd100) ? -12'sd100 : 12'(n_full);
      chain[0].x        <= fx[63:32];
      chain[0].t        <= m2f_pkg::OneQ31;
      chain[0].acc      <= s1_lin;
    end
  end

  // Chain of Horner cells, highest term first.
  for (genvar i = 0; i < N; i++) begin : g_cell
    m2f_horner_cell #(.K(N - i)) u_cell (
      .clk(clk), .rst(rst), .en(en), .din(chain[i]), .dout(chain[i+1]));
  end

  // Scaling stage: shift by n and multiply by the formula constant.
  logic [63:0]        e;
  logic signed [63:0] em;
  logic signed [63:0] prod;
  always_comb begin
    if (chain[N].n >= 0) e = 64'(chain[N].t) << chain[N].n[4:0];
    else if (chain[N].n <= -12'sd63) e = '0;
    else e = 64'(chain[N].t) >> 6'(-chain[N].n);
    em = chain[N].slaney ? signed'(e) : signed'(e) - 64'sd2147483648;
    prod = chain[N].slaney ? em * 64'sd1000
         : (chain[N].scale625 ? em * 64'sd625 : em * 64'sd700);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc.valid <= 1'b0;
    end else if (en) begin
      sc.valid <= chain[N].valid;
    end
    if (en) begin
      sc.path     <= chain[N].path;
      sc.scale625 <= chain[N].scale625;
      sc.slaney   <= chain[N].slaney;
      sc.n        <= chain[N].n;
      sc.x        <= chain[N].x;
      sc.t        <= chain[N].t;
      sc.acc      <= (chain[N].path == m2f_pkg::PATH_EXP) ? (prod >>> 19)
                     : chain[N].acc;
    end
  end

  // Output stage: saturate and register.
  logic signed [63:0] r;
  logic               sat;
  logic signed [31:0] r32;
  always_comb begin
    r   = (sc.path == m2f_pkg::PATH_ZERO) ? 64'sd0 : sc.acc;
    sat = 1'b0;
    r32 = r[31:0];
    if (sc.path == m2f_pkg::PATH_BIG || r > 64'sd2147483647) begin
      r32 = 32'h7FFF_FFFF;
      sat = 1'b1;
    end else if (r < -64'sd2147483648) begin
      r32 = 32'h8000_0000;
      sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sc.valid;
    end
    if (en) begin
      out_data <= {sat, r32};
    end
  end

  assign freq_ch.valid = out_valid;
  assign freq_ch.data  = out_data;

  // Conditions watched by the assertions.
  logic out_stall;
  logic at_clamp;
  assign out_stall = out_valid && !freq_ch.ready;
  assign at_clamp  = out_data[31:0] == 32'h7FFF_FFFF || out_data[31:0] == 32'h8000_0000;

  `M2F_ASSERT_IMP(a_stall_blocks, out_stall, !mel_ch.ready, "input not held")
  `M2F_ASSERT_NXT(a_hold, out_stall, out_valid && $stable(out_data), "result lost")
  `M2F_ASSERT_IMP(a_sat_ends, out_valid && out_data[32], at_clamp, "bad clamp")
endmodule

[hdl/m2f_horner_cell.sv]
// One Horner step of the e^x series, t = 1 + floor(x*t/2^31)/k, held in two
// register stages: the product first, then the division. Depends on m2f_pkg.
module m2f_horner_cell #(
  parameter int unsigned K = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  m2f_pkg::cell_data_t din,
  output m2f_pkg::cell_data_t dout
);
  // Reciprocal of K in Q36, rounded up. The error term stays below K, so the
  // quotient is exact for every dividend below 2^32.
  localparam longint unsigned RecipWide = ((64'd1 << 36) + 64'(K) - 64'd1) / 64'(K);
  localparam logic [36:0]     Recip     = RecipWide[36:0];

  logic [63:0] prod;
  logic [68:0] quot;
  m2f_pkg::cell_data_t mid_next;
  m2f_pkg::cell_data_t mid;
  m2f_pkg::cell_data_t dout_next;

  // First half: multiply and drop the Q31 scaling. The result fits 32 bits.
  always_comb begin
    prod       = 64'(din.x) * 64'(din.t);
    mid_next   = din;
    mid_next.t = prod[62:31];
  end

  // Second half: divide by the term's index through the reciprocal.
  always_comb begin
    quot        = 69'(mid.t) * 69'(Recip);
    dout_next   = mid;
    dout_next.t = m2f_pkg::OneQ31 + quot[67:36];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid  <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      mid.valid  <= mid_next.valid;
      dout.valid <= dout_next.valid;
    end
    if (en) begin
      mid.path      <= mid_next.path;
      mid.scale625  <= mid_next.scale625;
      mid.slaney    <= mid_next.slaney;
      mid.n         <= mid_next.n;
      mid.x         <= mid_next.x;
      mid.t         <= mid_next.t;
      mid.acc       <= mid_next.acc;
      dout.path     <= dout_next.path;
      dout.scale625 <= dout_next.scale625;
      dout.slaney   <= dout_next.slaney;
      dout.n        <= dout_next.n;
      dout.x        <= dout_next.x;
      dout.t        <= dout_next.t;
      dout.acc      <= dout_next.acc;
    end
  end
endmodule

[verif/tb_top.sv]
// Self-checking bench for the mel to frequency converter: drives random and
// edge-case mel values under all formula modes, predicts each frequency.
// Depends on m2f_pkg, m2f_if and mel_to_frequency from the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency = m2f_pkg::Stages;
  localparam longint CycleLimit = 600000;

  logic clk;
  logic rst;
  m2f_if #(.W(32)) mel_ch();
  m2f_if #(.W(2)) cfg_ch();
  m2f_if #(.W(33)) freq_ch();

  mel_to_frequency u_top (
    .clk(clk), .rst(rst), .mel_ch(mel_ch), .cfg_ch(cfg_ch), .freq_ch(freq_ch)
  );

  typedef struct packed {
    logic        saturated;
    logic [31:0] freq;
  } freq_t;

  // Stimulus entries: either a mel request or a mode change.
  typedef struct {
    bit             is_mode;
    bit             drain;
    m2f_pkg::mode_t mode;
    logic [31:0]    mel;
  } pending_t;

  pending_t       pending_q[$];
  freq_t          expected_freq_q[$];
  m2f_pkg::mode_t model_mode;
  int             mismatches;
  longint         cycle_count;
  bit             stimulus_done;
  int             sender_gap;
  int             receiver_gap;
  int             receiver_hold;
  int             hold_request_count;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // 2^y in Q31, y in Q32; flags an integer part of 20 or more.
  function automatic longint pow2_q31(longint y, output bit big);
    longint          n;
    longint unsigned f, x, t;
    n = floor_shr(y, 32);
    f = y & 64'hFFFF_FFFF;
    x = (f * 64'd1488522236) >> 32;
    t = 64'd1 << 31;
    for (int k = 12; k >= 1; k--) t = (64'd1 << 31) + ((x * t) >> 31) / k;
    big = (n >= 20);
    if (big) return 0;
    if (n >= 0) return longint'(t << n);
    if (-n >= 63) return 0;
    return longint'(t >> (-n));
  endfunction

  function automatic freq_t mel_to_hz(m2f_pkg::mode_t mode, logic [31:0] mel);
    longint m, r, d, e, q;
    bit     big;
    freq_t  res;
    m = longint'(signed'(mel));
    r = 0;
    big = 0;
    case (mode)
      m2f_pkg::MODE_OSH, m2f_pkg::MODE_LINDSAY: begin
        e = pow2_q31(floor_shr(m * ((mode == m2f_pkg::MODE_OSH) ? 64'sd1407513899 :
                                    64'sd1515559571), 24), big);
        if (!big) begin
          r = floor_shr(((mode == m2f_pkg::MODE_OSH) ? 700 : 625) * (e - (64'sd1 << 31)),
                        19);
        end
      end
      m2f_pkg::MODE_SLANEY: begin
        if (m < 15 * 65536) begin
          // Linear part below the knee, floor division by six.
          q = (25 * m) / 6;
          if (m < 0 && ((25 * m) % 6) != 0) q = q - 1;
          r = q;
        end else begin
          d = m - 15 * 65536;
          if (d > (64'sd1 << 26)) d = 64'sd1 << 26;
          e = pow2_q31(floor_shr(d * 64'sd109058192581, 24), big);
          if (!big) r = floor_shr(1000 * e, 19);
        end
      end
      default: r = 0;
    endcase
    res.saturated = 1'b0;
    if (big || r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      res.saturated = 1'b1;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      res.saturated = 1'b1;
    end
    res.freq = r[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  // Driver: mode changes wait for the chain to empty, requests follow gaps.
  always @(posedge clk) begin
    if (rst) begin
      mel_ch.valid <= 1'b0;
      mel_ch.data <= '0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.data <= '0;
      sender_gap <= 0;
      stimulus_done <= 1'b0;
      model_mode <= m2f_pkg::MODE_OSH;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      cfg_ch.valid <= 1'b0;
      model_mode <= m2f_pkg::mode_t'(cfg_ch.data);
    end else if (mel_ch.valid && !mel_ch.ready) begin
      // Hold the request until taken.
    end else begin
      if (mel_ch.valid) begin
        expected_freq_q.insert(expected_freq_q.size(), mel_to_hz(model_mode, mel_ch.data));
      end
      if (sender_gap > 0 || cfg_ch.valid) begin
        mel_ch.valid <= 1'b0;
        if (sender_gap > 0) sender_gap <= sender_gap - 1;
      end else if (pending_q.size() == 0) begin
        mel_ch.valid <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (pending_q[0].is_mode || pending_q[0].drain) begin
        mel_ch.valid <= 1'b0;
        if (expected_freq_q.size() == 0 && !mel_ch.valid && !freq_ch.valid) begin
          if (pending_q[0].is_mode) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data <= pending_q[0].mode;
          end
          void'(pending_q.pop_front());
        end
      end else begin
        mel_ch.valid <= 1'b1;
        mel_ch.data <= pending_q[0].mel;
        void'(pending_q.pop_front());
        sender_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
      end
    end
  end

  // Monitor and receiver: random stalls plus one long hold-off.
  always @(posedge clk) begin
    freq_t got;
    freq_t want;
    int    gap_draw;
    if (rst) begin
      freq_ch.ready <= 1'b0;
      receiver_gap <= 0;
      receiver_hold <= 0;
      hold_request_count <= 0;
    end else begin
      if (freq_ch.valid && freq_ch.ready) begin
        got = freq_ch.data;
        if (expected_freq_q.size() == 0) begin
          report_mismatch("unexpected result", got.freq, '0);
        end else begin
          want = expected_freq_q.pop_front();
          if (got.freq !== want.freq) report_mismatch("frequency_hz", got.freq, want.freq);
          if (got.saturated !== want.saturated) begin
            report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
          end
        end
        hold_request_count <= hold_request_count + 1;
      end
      if (receiver_hold > 0) begin
        receiver_hold <= receiver_hold - 1;
        freq_ch.ready <= 1'b0;
      end else if (freq_ch.valid && freq_ch.ready && hold_request_count == 300) begin
        // Long hold-off so that the chain fills and the input stalls.
        receiver_hold <= 200;
        freq_ch.ready <= 1'b0;
      end else if (freq_ch.valid && freq_ch.ready) begin
        gap_draw = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
        receiver_gap <= gap_draw;
        freq_ch.ready <= (gap_draw == 0);
      end else if (receiver_gap > 0) begin
        receiver_gap <= receiver_gap - 1;
        freq_ch.ready <= (receiver_gap == 1);
      end else begin
        freq_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_mel(logic [31:0] mel);
    pending_t p;
    p = '{is_mode: 0, drain: 0, mode: m2f_pkg::MODE_OSH, mel: mel};
    pending_q.insert(pending_q.size(), p);
  endtask

  task automatic add_mode(m2f_pkg::mode_t mode);
    pending_t p;
    p = '{is_mode: 1, drain: 0, mode: mode, mel: '0};
    pending_q.insert(pending_q.size(), p);
  endtask

  // Pause the sender until every expected result has come back.
  task automatic add_pause();
    pending_t p;
    p = '{is_mode: 0, drain: 1, mode: m2f_pkg::MODE_OSH, mel: '0};
    pending_q.insert(pending_q.size(), p);
  endtask

  // Random mel: any 32 bits, or 0 to 240, 0 to 32 or -256 to 0 mel in Q16.16.
  function automatic logic [31:0] random_mel();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h00F0_0000);
      2: return $urandom_range(0, 32'h0020_0000);
      default: return -$urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  initial begin
    automatic m2f_pkg::mode_t modes[4] = '{m2f_pkg::MODE_OSH, m2f_pkg::MODE_LINDSAY,
                                           m2f_pkg::MODE_SLANEY, m2f_pkg::MODE_NONE};
    rst = 1'b1;

    // Directed: extremes, the knee, huge exponents, unused mode, per mode.
    foreach (modes[i]) begin
      add_mode(modes[i]);
      add_mel(32'h0000_0000);
      add_mel(32'h7FFF_FFFF);
      add_mel(32'h8000_0000);
      add_mel(32'hFFFF_FFFF);
      add_mel(32'h000F_0000);
      add_mel(32'h000E_FFFF);
      add_mel(32'h0FA0_0000);
    end
    add_pause();
    // Random phases across all modes, extremes included.
    for (int ph = 0; ph < 10; ph++) begin
      add_mode(modes[$urandom_range(0, 3)]);
      for (int i = 0; i < 122; i++) add_mel(random_mel());
      if (ph == 4) add_pause();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (stimulus_done && expected_freq_q.size() == 0);
    repeat (Latency * 4) @(posedge clk);
    if (mismatches == 0 && expected_freq_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
